>>> hdl/ptt_pkg.sv
package ptt_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int TIME_W         = 16;
    localparam int VICTIM_W       = 8;
    localparam int ID_W           = 3;

    // command codes
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_ADDED   = 3'd0;
    localparam logic [2:0] KIND_FULL    = 3'd1;
    localparam logic [2:0] KIND_REMOVED = 3'd2;
    localparam logic [2:0] KIND_FIRED   = 3'd3;
    localparam logic [2:0] KIND_DONE    = 3'd4;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [TIME_W-1:0]   interval_ms;
        logic                repeat_flag;
        logic [VICTIM_W-1:0] slot_to_remove;
        logic [TIME_W-1:0]   elapsed_ms;
    } t_in_req;

    typedef struct packed {
        logic [2:0]      result_kind;
        logic [ID_W-1:0] slot_id;
        logic            last_of_run;
    } t_out_req;

    // shared compare/subtract unit result
    typedef struct packed {
        logic              expire;
        logic [TIME_W-1:0] diff;
    } t_cmp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_state;

endpackage

>>> hdl/periodic_task_timer_table.sv
// Add, remove: one request per cycle while not stalled, result registered for the next
// cycle; an unused code is taken and gives no result. Tick: one slot per cycle, unless
// a firing slot waits for the output, through the shared compare/subtract unit, then the
// done state; the next request is taken after the done result is loaded. Input is taken
// only in idle while the output register can accept a result.
// Synchronous active-low reset clears the busy and periodic marks and the sequencer.
module periodic_task_timer_table #(
    parameter int SLOT_COUNT = ptt_pkg::SLOT_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ptt_pkg::t_in_req  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ptt_pkg::t_out_req o_out_data
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // slot table: marks in flops with reset, time words without
    logic [SLOT_COUNT-1:0]     r_busy;
    logic [SLOT_COUNT-1:0]     r_periodic;
    logic [ptt_pkg::TIME_W-1:0] r_period    [SLOT_COUNT];
    logic [ptt_pkg::TIME_W-1:0] r_remaining [SLOT_COUNT];

    // sequencer
    ptt_pkg::t_state            r_state, n_state;
    logic [IDX_W-1:0]           r_idx;
    logic [ptt_pkg::TIME_W-1:0] r_elapsed;

    logic              in_acc;
    logic              out_free;
    logic              out_load;
    ptt_pkg::t_out_req out_data;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
    ptt_pkg::t_cmp     cmp;
    logic              cur_busy;
    logic              last_idx;
    logic              step_adv;
    logic              victim_ok;
    logic [IDX_W-1:0]  victim_idx;

    assign o_in_stall = !((r_state == ptt_pkg::ST_IDLE) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign cur_busy   = r_busy[r_idx];
    assign last_idx   = (r_idx == IDX_W'(SLOT_COUNT - 1));
    // a firing slot waits here until the output register has room
    assign step_adv   = !cur_busy || !cmp.expire || out_free;

    assign victim_ok  = (i_in_data.slot_to_remove < ptt_pkg::VICTIM_W'(SLOT_COUNT));
    assign victim_idx = i_in_data.slot_to_remove[IDX_W-1:0];

    ptt_free_find #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (IDX_W)
    ) u_free_find (
        .i_busy  (r_busy),
        .o_found (free_found),
        .o_idx   (free_idx)
    );

    // the one arithmetic unit, reused for every slot of a tick
    ptt_cmp_sub u_cmp_sub (
        .i_remaining (r_remaining[r_idx]),
        .i_elapsed   (r_elapsed),
        .o_res       (cmp)
    );

    ptt_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_data  (out_data),
        .i_stall (i_out_stall),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptt_pkg::ST_IDLE: begin
                if (in_acc && (i_in_data.cmd == ptt_pkg::CMD_TICK)) begin
                    n_state = ptt_pkg::ST_WALK;
                end
            end
            ptt_pkg::ST_WALK: begin
                if (step_adv && last_idx) begin
                    n_state = ptt_pkg::ST_DONE;
                end
            end
            ptt_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = ptt_pkg::ST_IDLE;
                end
            end
            default: n_state = ptt_pkg::ST_IDLE;
        endcase
    end

    // result generation
    always_comb begin
        out_load = 1'b0;
        out_data = '0;
        unique case (r_state)
            ptt_pkg::ST_IDLE: begin
                if (in_acc) begin
                    out_data.last_of_run = 1'b1;
                    case (i_in_data.cmd)
                        ptt_pkg::CMD_ADD: begin
                            out_load = 1'b1;
                            if (free_found) begin
                                out_data.result_kind = ptt_pkg::KIND_ADDED;
                                out_data.slot_id     = ptt_pkg::ID_W'(free_idx);
                            end else begin
                                out_data.result_kind = ptt_pkg::KIND_FULL;
                            end
                        end
                        ptt_pkg::CMD_REMOVE: begin
                            out_load             = 1'b1;
                            out_data.result_kind = ptt_pkg::KIND_REMOVED;
                        end
                        default: out_load = 1'b0;
                    endcase
                end
            end
            ptt_pkg::ST_WALK: begin
                if (cur_busy && cmp.expire && out_free) begin
                    out_load             = 1'b1;
                    out_data.result_kind = ptt_pkg::KIND_FIRED;
                    out_data.slot_id     = ptt_pkg::ID_W'(r_idx);
                end
            end
            ptt_pkg::ST_DONE: begin
                if (out_free) begin
                    out_load             = 1'b1;
                    out_data.result_kind = ptt_pkg::KIND_DONE;
                    out_data.last_of_run = 1'b1;
                end
            end
            default: out_load = 1'b0;
        endcase
    end

    // control state and slot marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ptt_pkg::ST_IDLE;
            r_idx      <= '0;
            r_busy     <= '0;
            r_periodic <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                case (i_in_data.cmd)
                    ptt_pkg::CMD_ADD: begin
                        if (free_found) begin
                            r_busy[free_idx]     <= 1'b1;
                            r_periodic[free_idx] <= i_in_data.repeat_flag;
                        end
                    end
                    ptt_pkg::CMD_REMOVE: begin
                        if (victim_ok) begin
                            r_busy[victim_idx]     <= 1'b0;
                            r_periodic[victim_idx] <= 1'b0;
                        end
                    end
                    ptt_pkg::CMD_TICK: begin
                        r_idx <= '0;
                    end
                    default: r_idx <= r_idx;
                endcase
            end
            if (r_state == ptt_pkg::ST_WALK) begin
                // one-shot slot that fires is freed
                if (cur_busy && cmp.expire && out_free && !r_periodic[r_idx]) begin
                    r_busy[r_idx]     <= 1'b0;
                    r_periodic[r_idx] <= 1'b0;
                end
                if (step_adv && !last_idx) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    // time words: single write port, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in_data.cmd == ptt_pkg::CMD_TICK)) begin
            r_elapsed <= i_in_data.elapsed_ms;
        end
        if (in_acc && (i_in_data.cmd == ptt_pkg::CMD_ADD) && free_found) begin
            r_period[free_idx]    <= i_in_data.interval_ms;
            r_remaining[free_idx] <= i_in_data.interval_ms;
        end else if ((r_state == ptt_pkg::ST_WALK) && cur_busy) begin
            if (!cmp.expire) begin
                r_remaining[r_idx] <= cmp.diff;
            end else if (out_free && r_periodic[r_idx]) begin
                r_remaining[r_idx] <= r_period[r_idx];
            end
        end
    end

    // requests are taken only while the sequencer is idle
    a_stall_outside_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ptt_pkg::ST_IDLE) |-> o_in_stall)
        else $error("input taken while sequencer busy");

    // a tick always starts its walk at slot zero
    a_walk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_data.cmd == ptt_pkg::CMD_TICK)) |=>
        ((r_state == ptt_pkg::ST_WALK) && (r_idx == '0)))
        else $error("tick walk did not start at slot zero");

    // fired results only come from occupied slots
    a_fire_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (out_data.result_kind == ptt_pkg::KIND_FIRED)) |-> cur_busy)
        else $error("free slot reported as fired");

    // a successful add leaves the claimed slot occupied
    a_add_claims: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_data.cmd == ptt_pkg::CMD_ADD) && free_found) |=>
        r_busy[$past(free_idx)])
        else $error("added slot not marked busy");

endmodule

>>> hdl/ptt_cmp_sub.sv
module ptt_cmp_sub (
    input  logic [ptt_pkg::TIME_W-1:0] i_remaining,
    input  logic [ptt_pkg::TIME_W-1:0] i_elapsed,
    output ptt_pkg::t_cmp              o_res
);

    logic [ptt_pkg::TIME_W:0] diff_ext;

    // one subtractor gives both the decrement and the compare
    assign diff_ext     = {1'b0, i_remaining} - {1'b0, i_elapsed};
    assign o_res.diff   = diff_ext[ptt_pkg::TIME_W-1:0];
    assign o_res.expire = diff_ext[ptt_pkg::TIME_W] ||
                          (diff_ext[ptt_pkg::TIME_W-1:0] == '0);

endmodule

>>> hdl/ptt_free_find.sv
module ptt_free_find #(
    parameter int SLOT_COUNT = ptt_pkg::SLOT_COUNT_DEF,
    parameter int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic [SLOT_COUNT-1:0] i_busy,
    output logic                  o_found,
    output logic [IDX_W-1:0]      o_idx
);

    // lowest free slot wins
    always_comb begin
        o_found = 1'b0;
        o_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!i_busy[i]) begin
                o_found = 1'b1;
                o_idx   = IDX_W'(i);
            end
        end
    end

endmodule

>>> hdl/ptt_out_reg.sv
module ptt_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ptt_pkg::t_out_req i_data,
    input  logic              i_stall,
    output logic              o_free,
    output logic              o_valid,
    output ptt_pkg::t_out_req o_data
);

    logic              r_valid;
    ptt_pkg::t_out_req r_data;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

endmodule
